// ----- rtl/core/mlss_pkg.sv -----
// ----------------------------------------------------------------------------
// mlss_pkg
// Shared types and constants of the multiplexed line sensor sequencer.
// ----------------------------------------------------------------------------
package mlss_pkg;

  // Width of the per-channel configuration registers and of line_bits.
  localparam int REG_W  = 6;
  // Width of a channel number.
  localparam int CHAN_W = 3;

  localparam logic [CHAN_W-1:0] NONE_CHANNEL = 3'd7;

  localparam logic [REG_W-1:0] ENABLE_RESET = 6'd63;
  localparam logic [REG_W-1:0] INVERT_RESET = 6'd57;

  // Event codes.
  localparam logic [2:0] MODE_RISE_TIMEOUT = 3'd0;
  localparam logic [2:0] MODE_FALL_TIMEOUT = 3'd1;
  localparam logic [2:0] MODE_RISE_EDGE    = 3'd2;
  localparam logic [2:0] MODE_FALL_EDGE    = 3'd3;
  localparam logic [2:0] MODE_START        = 3'd4;
  localparam logic [2:0] MODE_ACK          = 3'd5;

  // Sequencer phases.
  localparam logic [1:0] PHASE_WAIT_FALL = 2'd0;
  localparam logic [1:0] PHASE_MEASURING = 2'd1;
  localparam logic [1:0] PHASE_DRAINING  = 2'd2;
  localparam logic [1:0] PHASE_STOPPED   = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] CFG_CHANNEL_ENABLE = 1'd0;
  localparam logic [0:0] CFG_INVERT_MASK    = 1'd1;

  typedef struct packed {
    logic [2:0] mode;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic              drain_on;
    logic [CHAN_W-1:0] channel_select;
    logic [REG_W-1:0]  line_bits;
    logic              new_reading;
    logic              scan_complete;
    logic [1:0]        phase;
    logic              no_channel;
  } out_item_t;

  // Result of the round-robin channel pick.
  typedef struct packed {
    logic              found;
    logic [CHAN_W-1:0] channel;
    logic              wrap;
  } pick_t;

endpackage

// ----- rtl/core/mlss_intf.sv -----
// ----------------------------------------------------------------------------
// mlss_intf
// Handshake channels of the sequencer: event input, result output and
// configuration writes.
// ----------------------------------------------------------------------------
interface mlss_in_if;
  logic               valid;
  logic               ready;
  mlss_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface mlss_out_if;
  logic                valid;
  logic                ready;
  mlss_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface mlss_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [0:0]                  index;
  logic [mlss_pkg::REG_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/multiplexed_line_sensor_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// multiplexed_line_sensor_sequencer_core
// Each accepted event is held in an input register, applied to the sequencer
// state, and the state after the event is loaded into the result register,
// one result per event. Throughput is one event per clock unless a result
// stalls. An event passes through the input register and then the result
// register before its result is valid. A stalled result holds the input
// register, and one more event is taken while the result waits. The next
// enabled channel is found by a combinational round-robin pick over
// CHANNELS enable bits. Configuration writes are taken in any cycle and
// must only be issued while no event is in flight.
// ----------------------------------------------------------------------------
module multiplexed_line_sensor_sequencer_core #(
  parameter int CHANNELS = 6
) (
  input logic       clk,
  input logic       rst,
  mlss_in_if.sink   in,
  mlss_out_if.source out,
  mlss_cfg_if.sink  cfg
);

  logic                s1_valid;
  mlss_pkg::in_item_t  s1_item;
  logic                out_valid;
  mlss_pkg::out_item_t out_item;

  logic                go;
  logic                step;
  mlss_pkg::out_item_t result;

  // The held event advances whenever the result register is free or drains.
  assign go   = !out_valid || out.ready;
  assign step = s1_valid && go;

  assign in.ready  = !s1_valid || go;
  assign cfg.ready = 1'b1;
  assign out.valid = out_valid;
  assign out.item  = out_item;

  mlss_seq #(
    .CHANNELS (CHANNELS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .step      (step),
    .item      (s1_item),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in.valid && in.ready) begin
        s1_valid <= 1'b1;
      end else if (step) begin
        s1_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      s1_item <= in.item;
    end
    if (step) begin
      out_item <= result;
    end
  end

endmodule

// ----- rtl/core/mlss_pick.sv -----
// ----------------------------------------------------------------------------
// mlss_pick
// Round-robin pick of the next enabled channel after the current one.
// ----------------------------------------------------------------------------
module mlss_pick #(
  parameter int CHANNELS = 6
) (
  input  logic [CHANNELS-1:0]         en,
  input  logic [mlss_pkg::CHAN_W-1:0] cur,
  input  logic                        cur_valid,
  output mlss_pkg::pick_t             pick
);

  logic [CHANNELS-1:0]         above;
  logic [mlss_pkg::CHAN_W-1:0] low_ch;
  logic [mlss_pkg::CHAN_W-1:0] above_ch;

  always_comb begin
    low_ch   = '0;
    above_ch = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      above[i] = en[i] && (!cur_valid || (mlss_pkg::CHAN_W'(i) > cur));
      if (en[i]) begin
        low_ch = mlss_pkg::CHAN_W'(i);
      end
      if (above[i]) begin
        above_ch = mlss_pkg::CHAN_W'(i);
      end
    end
  end

  // With nothing enabled above the current channel the sequence wraps to the
  // lowest enabled one.
  always_comb begin
    pick.found   = |en;
    pick.channel = (|above) ? above_ch : low_ch;
    pick.wrap    = (|en) && !(|above);
  end

endmodule

// ----- rtl/core/mlss_seq.sv -----
// ----------------------------------------------------------------------------
// mlss_seq
// Sequencer state, configuration registers and the next-state logic for
// one event.
// ----------------------------------------------------------------------------
module mlss_seq #(
  parameter int CHANNELS = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [mlss_pkg::REG_W-1:0]       cfg_data,
  input  logic                             step,
  input  mlss_pkg::in_item_t               item,
  output mlss_pkg::out_item_t              result
);

  logic [mlss_pkg::REG_W-1:0]  channel_enable;
  logic [mlss_pkg::REG_W-1:0]  invert_mask;
  logic [1:0]                  phase_reg;
  logic [mlss_pkg::CHAN_W-1:0] cur_channel;
  logic                        cur_valid;
  logic [CHANNELS-1:0]         store;
  logic                        fresh;
  logic                        wrapped;
  logic                        drain;

  logic [1:0]                  phase_next;
  logic [mlss_pkg::CHAN_W-1:0] cur_channel_next;
  logic                        cur_valid_next;
  logic [CHANNELS-1:0]         store_next;
  logic                        fresh_next;
  logic                        wrapped_next;
  logic                        drain_next;

  logic [CHANNELS-1:0]         en_vec;
  logic [CHANNELS-1:0]         inv_vec;
  logic [CHANNELS-1:0]         cfg_vec;
  logic [mlss_pkg::REG_W-1:0]  line_bits;
  logic                        do_step;
  logic                        do_capture;
  mlss_pkg::pick_t             pick;

  // Channels without a register bit are never enabled and never inverted.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    if (i < mlss_pkg::REG_W) begin : g_reg
      assign en_vec[i]  = channel_enable[i];
      assign inv_vec[i] = invert_mask[i];
      assign cfg_vec[i] = cfg_data[i];
    end else begin : g_none
      assign en_vec[i]  = 1'b0;
      assign inv_vec[i] = 1'b0;
      assign cfg_vec[i] = 1'b0;
    end
  end

  mlss_pick #(
    .CHANNELS (CHANNELS)
  ) u_pick (
    .en        (en_vec),
    .cur       (cur_channel),
    .cur_valid (cur_valid),
    .pick      (pick)
  );

  always_comb begin
    phase_next       = phase_reg;
    cur_channel_next = cur_channel;
    cur_valid_next   = cur_valid;
    store_next       = store;
    fresh_next       = fresh;
    wrapped_next     = wrapped;
    drain_next       = drain;
    do_step          = 1'b0;
    do_capture       = 1'b0;

    case (item.mode) inside
      mlss_pkg::MODE_START: begin
        drain_next = 1'b1;
        do_step    = 1'b1;
        phase_next = mlss_pkg::PHASE_WAIT_FALL;
      end
      mlss_pkg::MODE_ACK: begin
        fresh_next = 1'b0;
      end
      mlss_pkg::MODE_RISE_TIMEOUT, mlss_pkg::MODE_FALL_TIMEOUT,
      mlss_pkg::MODE_RISE_EDGE, mlss_pkg::MODE_FALL_EDGE: begin
        unique case (phase_reg)
          mlss_pkg::PHASE_WAIT_FALL: begin
            if (item.mode == mlss_pkg::MODE_FALL_TIMEOUT) begin
              drain_next = 1'b0;
              phase_next = mlss_pkg::PHASE_MEASURING;
            end
          end
          mlss_pkg::PHASE_MEASURING: begin
            if (item.mode == mlss_pkg::MODE_RISE_TIMEOUT ||
                item.mode == mlss_pkg::MODE_RISE_EDGE) begin
              do_capture = 1'b1;
            end
          end
          mlss_pkg::PHASE_DRAINING: begin
            if (item.mode == mlss_pkg::MODE_FALL_TIMEOUT ||
                item.mode == mlss_pkg::MODE_FALL_EDGE) begin
              drain_next = 1'b0;
              phase_next = mlss_pkg::PHASE_MEASURING;
            end
          end
          mlss_pkg::PHASE_STOPPED: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (do_capture) begin
      // Only a chosen channel's store bit is written; the flag rises anyway.
      for (int i = 0; i < CHANNELS; i++) begin
        if (cur_valid && (mlss_pkg::CHAN_W'(i) == cur_channel)) begin
          store_next[i] = item.line_level ^ inv_vec[i];
        end
      end
      fresh_next = 1'b1;
      do_step    = 1'b1;
      drain_next = 1'b1;
      phase_next = mlss_pkg::PHASE_DRAINING;
    end

    if (do_step && pick.found) begin
      cur_channel_next = pick.channel;
      cur_valid_next   = 1'b1;
      wrapped_next     = wrapped | pick.wrap;
    end
  end

  for (genvar j = 0; j < mlss_pkg::REG_W; j++) begin : g_bits
    if (j < CHANNELS) begin : g_live
      assign line_bits[j] = store_next[j] | ~en_vec[j];
    end else begin : g_dead
      assign line_bits[j] = 1'b0;
    end
  end

  always_comb begin
    result.drain_on       = drain_next;
    result.channel_select = cur_channel_next;
    result.line_bits      = line_bits;
    result.new_reading    = fresh_next;
    result.scan_complete  = wrapped_next;
    result.phase          = phase_next;
    result.no_channel     = ~(|en_vec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= mlss_pkg::ENABLE_RESET;
      invert_mask    <= mlss_pkg::INVERT_RESET;
      phase_reg      <= mlss_pkg::PHASE_STOPPED;
      cur_channel    <= mlss_pkg::NONE_CHANNEL;
      cur_valid      <= 1'b0;
      store          <= '1;
      fresh          <= 1'b0;
      wrapped        <= 1'b0;
      drain          <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlss_pkg::CFG_CHANNEL_ENABLE: begin
          // A channel being disabled has its stored reading forced to 1.
          store          <= store | (en_vec & ~cfg_vec);
          channel_enable <= cfg_data;
        end
        mlss_pkg::CFG_INVERT_MASK: begin
          invert_mask <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (step) begin
      phase_reg   <= phase_next;
      cur_channel <= cur_channel_next;
      cur_valid   <= cur_valid_next;
      store       <= store_next;
      fresh       <= fresh_next;
      wrapped     <= wrapped_next;
      drain       <= drain_next;
    end
  end

endmodule
